>>> src/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg: shared types, constants and calendar functions
// Request codes, reciprocal constants and the day-number helpers used by
// the date calculator pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dda_pkg;

  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_DIFF = 2'd1;
  localparam logic [1:0] REQ_WDAY = 2'd2;
  localparam logic [1:0] REQ_CMP  = 2'd3;

  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [21:0] DAY_LAST   = 22'd3652059;
  // floor(x/25) = (x*RECIP_25) >> 16 for every x below 4681.
  localparam logic [11:0] RECIP_25   = 12'd2622;
  // floor(x/7) = (x*RECIP_7) >> 25 for every 22-bit x.
  localparam logic [22:0] RECIP_7    = 23'd4793491;
  // 400/146097 scaled by 2^32, for the year estimate.
  localparam logic [23:0] RECIP_YEAR = 24'd11759221;

  typedef struct packed {
    logic [1:0]         req;
    logic               av;
    logic               err;
    logic signed [23:0] n;
    logic [21:0]        dna;
    logic signed [22:0] diff;
    logic               gt;
    logic               eq;
    logic [2:0]         wd;
  } carry_t;

  typedef struct packed {
    logic        ok;
    logic [21:0] dn;
  } dnum_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      4'd2: r = leap ? 5'd29 : 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Days in the year before the first of month m.
  function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
    logic [8:0] r;
    case (m)
      4'd1: r = 9'd0;
      4'd2: r = 9'd31;
      4'd3: r = 9'd59;
      4'd4: r = 9'd90;
      4'd5: r = 9'd120;
      4'd6: r = 9'd151;
      4'd7: r = 9'd181;
      4'd8: r = 9'd212;
      4'd9: r = 9'd243;
      4'd10: r = 9'd273;
      4'd11: r = 9'd304;
      4'd12: r = 9'd334;
      default: r = 9'd0;
    endcase
    if (leap && m > 4'd2) r = r + 9'd1;
    return r;
  endfunction

  // Day number of January 1 of year p+1, from registered /25 products.
  function automatic logic [21:0] year_start(input logic [13:0] p,
                                             input logic [23:0] prod100,
                                             input logic [21:0] prod400);
    return 22'(p) * 22'd365 + 22'(p[13:2]) - 22'(prod100[23:16])
           + 22'(prod400[21:16]) + 22'd1;
  endfunction

  function automatic dnum_t day_num(input logic [13:0] y, input logic [3:0] m,
                                    input logic [4:0] d,
                                    input logic [23:0] p100, input logic [21:0] p400,
                                    input logic [23:0] y100, input logic [21:0] y400);
    dnum_t       r;
    logic [11:0] r25;
    logic [9:0]  r25h;
    logic        leap;
    r25  = y[13:2] - 12'(y100[23:16] * 8'd25);
    r25h = y[13:4] - 10'(y400[21:16] * 6'd25);
    leap = (y[1:0] == 2'd0) && ((r25 != 12'd0) || ((y[3:0] == 4'd0) && (r25h == 10'd0)));
    r.ok = (y != 14'd0) && (y <= YEAR_MAX) && (m != 4'd0) && (m <= 4'd12) &&
           (d != 5'd0) && (d <= month_len(m, leap));
    r.dn = year_start(y - 14'd1, p100, p400) + 22'(cum_days(m, leap)) + 22'(d) - 22'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/date_day_arithmetic.sv
// ----------------------------------------------------------------------------
// date_day_arithmetic: Gregorian date calculator
// Add a day offset to a date, subtract two dates, find a weekday or compare.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready with dates A and B, a signed offset and
// req_type; one result leaves on out_valid/out_ready for every request.
// The block is an eight-stage pipeline, and one request is taken every cycle
// while the result side keeps up. The stages are set by the chain of the
// conversion of a day number back to a date: year estimate multiply, /25
// products of four candidate years, their day numbers, then month search.
// The whole pipeline moves together; when the final stage holds a result that
// is not taken, every stage holds and in_ready is low, so nothing is lost or
// repeated. in_ready stays high while the output is empty or being taken.
// Reset clears all valid bits; the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module date_day_arithmetic (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         req_type,
  input  wire logic [13:0]        a_year,
  input  wire logic [3:0]         a_month,
  input  wire logic [4:0]         a_day,
  input  wire logic [13:0]        b_year,
  input  wire logic [3:0]         b_month,
  input  wire logic [4:0]         b_day,
  input  wire logic signed [20:0] day_offset,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [13:0]             res_year,
  output logic [3:0]              res_month,
  output logic [4:0]              res_day,
  output logic signed [22:0]      day_difference,
  output logic [2:0]              weekday,
  output logic                    a_greater,
  output logic                    a_equal,
  output logic                    a_valid,
  output logic                    range_error
);

  logic [7:1] vld;
  logic       en;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[6:1], in_valid};
      out_valid <= vld[7];
    end
  end

  // Stage 1: inputs and the /25 products.
  logic [1:0]         s1_req;
  logic [13:0]        s1_ay, s1_by;
  logic [3:0]         s1_am, s1_bm;
  logic [4:0]         s1_ad, s1_bd;
  logic signed [20:0] s1_off;
  logic [23:0]        s1_pa100, s1_pb100, s1_ya100, s1_yb100;
  logic [21:0]        s1_pa400, s1_pb400, s1_ya400, s1_yb400;
  logic [13:0]        pa, pb;

  assign pa = a_year - 14'd1;
  assign pb = b_year - 14'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_req   <= req_type;
      s1_ay    <= a_year;
      s1_am    <= a_month;
      s1_ad    <= a_day;
      s1_by    <= b_year;
      s1_bm    <= b_month;
      s1_bd    <= b_day;
      s1_off   <= day_offset;
      s1_pa100 <= 24'(pa[13:2]) * 24'(dda_pkg::RECIP_25);
      s1_pa400 <= 22'(pa[13:4]) * 22'(dda_pkg::RECIP_25);
      s1_pb100 <= 24'(pb[13:2]) * 24'(dda_pkg::RECIP_25);
      s1_pb400 <= 22'(pb[13:4]) * 22'(dda_pkg::RECIP_25);
      s1_ya100 <= 24'(a_year[13:2]) * 24'(dda_pkg::RECIP_25);
      s1_ya400 <= 22'(a_year[13:4]) * 22'(dda_pkg::RECIP_25);
      s1_yb100 <= 24'(b_year[13:2]) * 24'(dda_pkg::RECIP_25);
      s1_yb400 <= 22'(b_year[13:4]) * 22'(dda_pkg::RECIP_25);
    end
  end

  // Stage 2: validity and day numbers.
  dda_pkg::dnum_t     s2_a, s2_b, dn_a, dn_b;
  logic [1:0]         s2_req;
  logic signed [20:0] s2_off;

  assign dn_a = dda_pkg::day_num(s1_ay, s1_am, s1_ad, s1_pa100, s1_pa400,
                                 s1_ya100, s1_ya400);
  assign dn_b = dda_pkg::day_num(s1_by, s1_bm, s1_bd, s1_pb100, s1_pb400,
                                 s1_yb100, s1_yb400);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_a   <= dn_a;
      s2_b   <= dn_b;
      s2_req <= s1_req;
      s2_off <= s1_off;
    end
  end

  // Stage 3: shifted day number, difference, compare, weekday product.
  dda_pkg::carry_t s3, s4, s5, s6, s7;
  logic [44:0]     s3_wprod;

  always_ff @(posedge clk) begin
    if (en) begin
      s3.req  <= s2_req;
      s3.av   <= s2_a.ok;
      s3.err  <= !s2_a.ok || (((s2_req == dda_pkg::REQ_DIFF) ||
                               (s2_req == dda_pkg::REQ_CMP)) && !s2_b.ok);
      s3.n    <= $signed({2'b00, s2_a.dn}) + 24'(s2_off);
      s3.dna  <= s2_a.dn;
      s3.diff <= $signed({1'b0, s2_a.dn}) - $signed({1'b0, s2_b.dn});
      s3.gt   <= s2_a.dn > s2_b.dn;
      s3.eq   <= s2_a.dn == s2_b.dn;
      s3.wd   <= 3'd0;
      s3_wprod <= 45'(s2_a.dn) * 45'(dda_pkg::RECIP_7);
    end
  end

  // Stage 4: range check, year estimate product, weekday.
  logic [45:0]     s4_eprod;
  logic [21:0]     wrem;
  logic [2:0]      wr;
  logic            n_in_range;
  dda_pkg::carry_t s4_next;

  assign wrem = s3.dna - 22'(s3_wprod[44:25] * 20'd7);
  assign wr   = wrem[2:0];
  assign n_in_range = (s3.n >= 24'sd1) && (s3.n <= $signed({2'b00, dda_pkg::DAY_LAST}));

  always_comb begin
    s4_next    = s3;
    // Day number of 1900-01-01 is one above a multiple of seven.
    s4_next.wd = (wr == 3'd0) ? 3'd6 : wr - 3'd1;
    if (s3.req == dda_pkg::REQ_ADD && !n_in_range) s4_next.err = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4       <= s4_next;
      s4_eprod <= 46'(s3.n[21:0] - 22'd1) * 46'(dda_pkg::RECIP_YEAR);
    end
  end

  // Stage 5: candidate years and their /25 products.
  logic [13:0] y0, yb;
  logic [13:0] s5_yb;
  logic [23:0] s5_p100 [4];
  logic [21:0] s5_p400 [4];

  assign y0 = s4_eprod[45:32] + 14'd1;
  assign yb = (y0 > 14'd1) ? y0 - 14'd1 : 14'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      s5    <= s4;
      s5_yb <= yb;
      for (int i = 0; i < 4; i++) begin
        s5_p100[i] <= 24'(12'((yb - 14'd1 + 14'(i)) >> 2)) * 24'(dda_pkg::RECIP_25);
        s5_p400[i] <= 22'(10'((yb - 14'd1 + 14'(i)) >> 4)) * 22'(dda_pkg::RECIP_25);
      end
    end
  end

  // Stage 6: start of each candidate year.
  logic [13:0] s6_yb;
  logic [21:0] s6_ys [4];

  always_ff @(posedge clk) begin
    if (en) begin
      s6    <= s5;
      s6_yb <= s5_yb;
      for (int i = 0; i < 4; i++) begin
        s6_ys[i] <= dda_pkg::year_start(s5_yb - 14'd1 + 14'(i), s5_p100[i], s5_p400[i]);
      end
    end
  end

  // Stage 7: pick the year, day within the year.
  logic [13:0] s7_y;
  logic [8:0]  s7_rem;
  logic        s7_leap;
  logic [1:0]  ysel;
  logic [21:0] ys_lo, ys_hi;

  always_comb begin
    if (s6_ys[2] <= s6.n[21:0]) ysel = 2'd2;
    else if (s6_ys[1] <= s6.n[21:0]) ysel = 2'd1;
    else ysel = 2'd0;
    ys_lo = s6_ys[ysel];
    ys_hi = s6_ys[ysel + 2'd1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7      <= s6;
      s7_y    <= s6_yb + 14'(ysel);
      s7_rem  <= 9'(s6.n[21:0] - ys_lo);
      s7_leap <= (ys_hi - ys_lo) == 22'd366;
    end
  end

  // Stage 8: month search and result selection.
  logic [3:0] mon;
  logic [4:0] dom;
  logic       take_add, take_diff, take_wday, take_cmp;

  always_comb begin
    mon = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (dda_pkg::cum_days(4'(k), s7_leap) <= s7_rem) mon = mon + 4'd1;
    end
    dom = 5'(s7_rem - dda_pkg::cum_days(mon, s7_leap) + 9'd1);
  end

  // Unproduced fields are zero; an error zeroes all but a_valid and range_error.
  assign take_add  = !s7.err && (s7.req == dda_pkg::REQ_ADD);
  assign take_diff = !s7.err && (s7.req == dda_pkg::REQ_DIFF);
  assign take_wday = !s7.err && (s7.req == dda_pkg::REQ_WDAY);
  assign take_cmp  = !s7.err && (s7.req == dda_pkg::REQ_CMP);

  always_ff @(posedge clk) begin
    if (en) begin
      res_year       <= take_add ? s7_y : 14'd0;
      res_month      <= take_add ? mon : 4'd0;
      res_day        <= take_add ? dom : 5'd0;
      day_difference <= take_diff ? s7.diff : 23'sd0;
      weekday        <= take_wday ? s7.wd : 3'd0;
      a_greater      <= take_cmp && s7.gt;
      a_equal        <= take_cmp && s7.eq;
      a_valid        <= s7.av;
      range_error    <= s7.err;
    end
  end

endmodule

`default_nettype wire

>>> src/dda_checker.sv
// ----------------------------------------------------------------------------
// dda_checker: port-level checks for the date calculator
// Watches the result channel for reset, stall and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [13:0] res_year,
  input wire logic [3:0]  res_month,
  input wire logic [4:0]  res_day,
  input wire logic [22:0] day_difference,
  input wire logic        a_greater,
  input wire logic        a_equal,
  input wire logic        range_error
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_year) &&
    $stable(day_difference) && $stable(range_error))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> res_year == 14'd0 && res_month == 4'd0 &&
    res_day == 5'd0 && day_difference == 23'd0 && !a_greater && !a_equal)
    else $error("error result carries data");

  a_date_whole: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_month != 4'd0 |-> res_day != 5'd0 && res_year != 14'd0 &&
    res_month <= 4'd12)
    else $error("partial shifted date");

  a_cmp_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(a_greater && a_equal))
    else $error("compare flags both set");

endmodule

bind date_day_arithmetic dda_checker u_dda_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .res_year(res_year), .res_month(res_month), .res_day(res_day),
  .day_difference(day_difference), .a_greater(a_greater), .a_equal(a_equal),
  .range_error(range_error)
);

`default_nettype wire
